FILE: src/buddy_page_allocator_core_macros.svh
// Assertion macros for the buddy page allocator core
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT_SAME(lbl, ante, cons, msg)
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int TOP_ORDER    = 10;
  localparam int REGION_PAGES = 32768;
  localparam int OFF_W        = 15;
  localparam int LEN_W        = 16;
  localparam int PAGE_W       = 28;
  localparam int ORD_W        = 4;
  localparam int NUM_LISTS    = TOP_ORDER + 1;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_BAD_PAGE = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ALLOC_SCAN, S_ALLOC_POP, S_SPLIT,
    S_REL_CHECK, S_WALK, S_WALK_WAIT, S_PUSH, S_DONE
  } state_e;

  typedef struct packed {
    logic             we;
    logic [OFF_W-1:0] waddr;
    logic [OFF_W-1:0] wdata;
    logic [OFF_W-1:0] raddr;
  } link_req_t;
endpackage

FILE: src/buddy_page_allocator_core.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid_i/in_stall_o | opcode_i, block_order_i, free_page_i
// out      | output    | out_valid_o/out_stall_i | status_o, granted_page_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// One item at a time; in_stall_o is high from acceptance until the result is loaded.
// Init: each carved block passes S_INIT, S_REL_CHECK, its buddy walks and S_PUSH; orders step down in S_INIT.
// Alloc: S_ALLOC_SCAN per order scanned, then S_ALLOC_POP, then S_SPLIT and S_PUSH per split.
// Free: an S_REL_CHECK per order checked, then S_WALK and S_WALK_WAIT per entry walked, then S_PUSH.
// A rejected free or an unknown opcode goes straight to S_DONE; each entry walked is one memory read.
// Reset clears lists and control, not the link memory; out_stall_i delays only the load.
`include "buddy_page_allocator_core_macros.svh"
module buddy_page_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [bpa_pkg::ORD_W-1:0]   block_order_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  free_page_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [bpa_pkg::PAGE_W-1:0]  granted_page_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  cfg_data_i
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  logic [PAGE_W-1:0] start_q, end_q;
  logic [OFF_W-1:0]  head_q [NUM_LISTS];
  logic [LEN_W-1:0]  len_q  [NUM_LISTS];

  logic [1:0]        op_q, op_d;
  logic [ORD_W-1:0]  ord_q, ord_d;
  logic [ORD_W-1:0]  rel_o_q, rel_o_d;
  logic [OFF_W-1:0]  rel_off_q, rel_off_d;
  logic [OFF_W-1:0]  cur_q, cur_d, prev_q, prev_d, r_q, r_d;
  logic [LEN_W-1:0]  walk_i_q, walk_i_d;
  logic [LEN_W-1:0]  p_q, p_d;
  logic [ORD_W-1:0]  io_q, io_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [PAGE_W-1:0] res_page_q, res_page_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [PAGE_W-1:0] out_page_q, out_page_d;

  logic              lst_clr, lst_head_we, lst_inc, lst_dec;
  logic [OFF_W-1:0]  lst_head_wd;
  link_req_t         link_req;
  logic [OFF_W-1:0]  link_rdata;

  logic [PAGE_W-1:0] diff, page_off;
  logic [LEN_W-1:0]  size;
  logic              idx_ok;
  logic [OFF_W-1:0]  cur_head, bud, obit;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W:0]    p_next;
  logic              in_xfer;

  bpa_link_store u_store (
    .clk_i  (clk_i),
    .req_i  (link_req),
    .rdata_o(link_rdata)
  );

  assign diff     = end_q - start_q;
  assign size     = (end_q <= start_q) ? '0 :
                    (diff > PAGE_W'(REGION_PAGES)) ? LEN_W'(REGION_PAGES) : diff[LEN_W-1:0];
  assign page_off = free_page_i - start_q;
  assign idx_ok   = (rel_o_q <= ORD_W'(TOP_ORDER));
  assign cur_head = idx_ok ? head_q[rel_o_q] : '0;
  assign cur_len  = idx_ok ? len_q[rel_o_q] : '0;
  assign obit     = OFF_W'(1) << rel_o_q;
  assign bud      = rel_off_q ^ obit;
  assign p_next   = {1'b0, p_q} + ((LEN_W+1)'(1) << io_q);

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_page_o = out_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= PAGE_W'(524288);
      end_q       <= PAGE_W'(557056);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_START) begin
          start_q <= cfg_data_i;
        end else if (cfg_index_i == REG_END) begin
          end_q <= cfg_data_i;
        end
      end
    end
  end

  // free-list heads and lengths, addressed by the current order; a clear resets all lists
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        head_q[k] <= '0;
        len_q[k]  <= '0;
      end
    end else if (lst_clr) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        head_q[k] <= '0;
        len_q[k]  <= '0;
      end
    end else if (idx_ok) begin
      if (lst_head_we) begin
        head_q[rel_o_q] <= lst_head_wd;
      end
      if (lst_inc) begin
        len_q[rel_o_q] <= len_q[rel_o_q] + LEN_W'(1);
      end else if (lst_dec) begin
        len_q[rel_o_q] <= len_q[rel_o_q] - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ord_q        <= ord_d;
    rel_o_q      <= rel_o_d;
    rel_off_q    <= rel_off_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    r_q          <= r_d;
    walk_i_q     <= walk_i_d;
    p_q          <= p_d;
    io_q         <= io_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ord_d        = ord_q;
    rel_o_d      = rel_o_q;
    rel_off_d    = rel_off_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    r_d          = r_q;
    walk_i_d     = walk_i_q;
    p_d          = p_q;
    io_d         = io_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    lst_clr      = 1'b0;
    lst_head_we  = 1'b0;
    lst_head_wd  = '0;
    lst_inc      = 1'b0;
    lst_dec      = 1'b0;
    link_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d         = opcode_i;
          ord_d        = block_order_i;
          res_status_d = ST_OK;
          res_page_d   = '0;
          case (opcode_i)
            OP_INIT: begin
              lst_clr = 1'b1;
              p_d     = '0;
              io_d    = ORD_W'(TOP_ORDER);
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              rel_o_d = block_order_i;
              state_d = S_ALLOC_SCAN;
            end
            OP_FREE: begin
              if (free_page_i < start_q || page_off >= PAGE_W'(size)) begin
                res_status_d = ST_BAD_PAGE;
                state_d      = S_DONE;
              end else begin
                rel_off_d = page_off[OFF_W-1:0];
                rel_o_d   = (block_order_i > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER)
                                                                 : block_order_i;
                state_d   = S_REL_CHECK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        // carve the largest block that still fits, then step the order down
        if (p_next <= {1'b0, size}) begin
          rel_off_d = p_q[OFF_W-1:0];
          rel_o_d   = io_q;
          p_d       = p_next[LEN_W-1:0];
          state_d   = S_REL_CHECK;
        end else if (io_q == '0) begin
          state_d = S_DONE;
        end else begin
          io_d = io_q - ORD_W'(1);
        end
      end
      S_ALLOC_SCAN: begin
        if (!idx_ok) begin
          res_status_d = ST_NO_BLOCK;
          state_d      = S_DONE;
        end else if (cur_len == '0) begin
          rel_o_d = rel_o_q + ORD_W'(1);
        end else begin
          r_d            = cur_head;
          link_req.raddr = cur_head;
          state_d        = S_ALLOC_POP;
        end
      end
      S_ALLOC_POP: begin
        lst_head_we = 1'b1;
        lst_head_wd = link_rdata;
        lst_dec     = 1'b1;
        state_d     = S_SPLIT;
      end
      S_SPLIT: begin
        if (rel_o_q > ord_q) begin
          rel_o_d   = rel_o_q - ORD_W'(1);
          rel_off_d = r_q ^ (OFF_W'(1) << (rel_o_q - ORD_W'(1)));
          state_d   = S_PUSH;
        end else begin
          res_page_d = start_q + PAGE_W'(r_q);
          state_d    = S_DONE;
        end
      end
      S_REL_CHECK: begin
        if (rel_o_q < ORD_W'(TOP_ORDER) && {1'b0, bud} < size) begin
          cur_d    = cur_head;
          prev_d   = '0;
          walk_i_d = '0;
          state_d  = S_WALK;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_WALK: begin
        if (walk_i_q >= cur_len) begin
          state_d = S_PUSH;
        end else begin
          link_req.raddr = cur_q;
          state_d        = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (cur_q == bud) begin
          // unlink the buddy and merge one order up
          if (walk_i_q == '0) begin
            lst_head_we = 1'b1;
            lst_head_wd = link_rdata;
          end else begin
            link_req.we    = 1'b1;
            link_req.waddr = prev_q;
            link_req.wdata = link_rdata;
          end
          lst_dec   = 1'b1;
          rel_off_d = rel_off_q & ~obit;
          rel_o_d   = rel_o_q + ORD_W'(1);
          state_d   = S_REL_CHECK;
        end else begin
          prev_d   = cur_q;
          cur_d    = link_rdata;
          walk_i_d = walk_i_q + LEN_W'(1);
          state_d  = S_WALK;
        end
      end
      S_PUSH: begin
        if (cur_len < LEN_W'(REGION_PAGES)) begin
          link_req.we    = 1'b1;
          link_req.waddr = rel_off_q;
          link_req.wdata = cur_head;
          lst_head_we    = 1'b1;
          lst_head_wd    = rel_off_q;
          lst_inc        = 1'b1;
        end
        case (op_q)
          OP_INIT:  state_d = S_INIT;
          OP_ALLOC: state_d = S_SPLIT;
          default:  state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = res_page_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `BPA_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_q != S_IDLE, "accepted item left no work")
  `BPA_ASSERT_SAME(a_walk_in_list, state_q == S_WALK_WAIT, walk_i_q < cur_len, "walk past list")
  `BPA_ASSERT_SAME(a_nospace_zero, out_valid_q && out_status_q != ST_OK, out_page_q == '0, "page on error")
endmodule

FILE: src/bpa_link_store.sv
`timescale 1ns / 1ps
module bpa_link_store (
  input  logic                     clk_i,
  input  bpa_pkg::link_req_t       req_i,
  output logic [bpa_pkg::OFF_W-1:0] rdata_o
);
  import bpa_pkg::*;

  logic [OFF_W-1:0] mem [REGION_PAGES];
  logic [OFF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: dv/tb_buddy_page_allocator_core.sv
`timescale 1ns / 1ps
module tb_buddy_page_allocator_core;
  import bpa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [27:0] PAGE_MASK = 28'hFFFFFFF;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  // Free-list predictor: offsets from the region start, one LIFO list per order
  class alloc_scoreboard;
    int unsigned base_page, limit_page;
    int unsigned link_mem[REGION_PAGES];
    int unsigned list_len[NUM_LISTS];
    int unsigned list_top[NUM_LISTS];
    logic [29:0] want_q[$];
    int errors;

    function new();
      base_page = 524288;
      limit_page = 557056;
      foreach (list_len[i]) begin
        list_len[i] = 0;
        list_top[i] = 0;
      end
      errors = 0;
    endfunction

    function int unsigned span();
      int unsigned n;
      if (limit_page <= base_page) return 0;
      n = limit_page - base_page;
      return (n > REGION_PAGES) ? REGION_PAGES : n;
    endfunction

    function void push_free(int unsigned o, int unsigned off);
      if (off >= REGION_PAGES || list_len[o] >= REGION_PAGES) return;
      link_mem[off] = list_top[o];
      list_top[o] = off;
      list_len[o]++;
    endfunction

    function bit unlink_free(int unsigned o, int unsigned off);
      int unsigned cur, prev;
      cur = list_top[o];
      prev = 0;
      for (int unsigned i = 0; i < list_len[o]; i++) begin
        if (cur == off) begin
          if (i == 0) list_top[o] = link_mem[cur];
          else link_mem[prev] = link_mem[cur];
          list_len[o]--;
          return 1;
        end
        prev = cur;
        cur = link_mem[cur];
      end
      return 0;
    endfunction

    function void merge_and_push(int unsigned off, int unsigned o, int unsigned sz);
      int unsigned b;
      while (o < TOP_ORDER) begin
        b = off ^ (32'd1 << o);
        if (b >= sz || !unlink_free(o, b)) break;
        if (b < off) off = b;
        o++;
      end
      push_free(o, off);
    endfunction

    function void carve();
      int unsigned sz, p, s;
      int o;
      sz = span();
      p = 0;
      foreach (list_len[i]) begin
        list_len[i] = 0;
        list_top[i] = 0;
      end
      while (p + (32'd1 << TOP_ORDER) <= sz) begin
        merge_and_push(p, TOP_ORDER, sz);
        p += 32'd1 << TOP_ORDER;
      end
      o = TOP_ORDER - 1;
      while (o >= 0 && p < sz) begin
        s = 32'd1 << o;
        if (p + s <= sz) begin
          merge_and_push(p, o, sz);
          p += s;
        end else begin
          o--;
        end
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [27:0] v);
      if (idx == REG_START) base_page = 32'(v);
      else if (idx == REG_END) limit_page = 32'(v);
    endfunction

    // Returns {status, granted page}
    function logic [29:0] note_request(logic [1:0] op, logic [3:0] ord, logic [27:0] page);
      logic [1:0] st;
      logic [27:0] granted;
      int unsigned c, r, sz, o;
      st = ST_OK;
      granted = '0;
      if (op == OP_INIT) begin
        carve();
      end else if (op == OP_ALLOC) begin
        c = 32'(ord);
        while (c <= TOP_ORDER && list_len[c] == 0) c++;
        if (c > TOP_ORDER) begin
          st = ST_NO_BLOCK;
        end else begin
          r = list_top[c];
          list_top[c] = link_mem[r];
          list_len[c]--;
          while (c > ord) begin
            c--;
            push_free(c, r ^ (32'd1 << c));
          end
          granted = 28'(base_page + r);
        end
      end else if (op == OP_FREE) begin
        sz = span();
        if (page < base_page || page - base_page >= sz) begin
          st = ST_BAD_PAGE;
        end else begin
          o = (ord > TOP_ORDER) ? TOP_ORDER : 32'(ord);
          merge_and_push(page - base_page, o, sz);
        end
      end
      want_q.push_back({st, granted});
      return {st, granted};
    endfunction

    function void check_result(logic [1:0] st, logic [27:0] granted);
      logic [29:0] w;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d page 0x%07h", st, granted);
        return;
      end
      w = want_q.pop_front();
      if (w[29:28] !== st || w[27:0] !== granted) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d page 0x%07h, got status %0d page 0x%07h",
                   w[29:28], w[27:0], st, granted);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  typedef struct {
    logic [27:0] page;
    logic [3:0] ord;
  } held_block_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] opcode_i;
  logic [ORD_W-1:0] block_order_i;
  logic [PAGE_W-1:0] free_page_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] status_o;
  logic [PAGE_W-1:0] granted_page_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [PAGE_W-1:0] cfg_data_i;

  buddy_page_allocator_core dut (.*);

  alloc_scoreboard sb = new();
  held_block_t held_q[$];
  held_block_t last_freed;
  bit have_freed;
  bit quiet;
  int unsigned cycles = 0;
  int unsigned sink_wait;
  int n_grant, n_empty, n_reject, n_settings;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_buddy_page_allocator_core NOT OK");
      $finish;
    end
  end

  // Result side: check each transfer, then hold stall for a random wait unless quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_wait = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, granted_page_o);
        sink_wait = quiet ? 0 : $urandom_range(0, 18);
      end else if (sink_wait > 0) begin
        sink_wait = sink_wait - 1;
      end
      out_stall_i <= (sink_wait != 0);
    end
  end

  task automatic send(logic [1:0] op, logic [3:0] ord, logic [27:0] page);
    int gap;
    logic [29:0] res;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    block_order_i <= ord;
    free_page_i <= page;
    do @(posedge clk_i); while (in_stall_o);
    res = sb.note_request(op, ord, page);
    if (op == OP_INIT) held_q.delete();
    if (res[29:28] == ST_NO_BLOCK) n_empty++;
    if (res[29:28] == ST_BAD_PAGE) n_reject++;
    if (op == OP_ALLOC && res[29:28] == ST_OK) begin
      n_grant++;
      held_q.push_back('{page: res[27:0], ord: ord});
    end
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_region(logic [27:0] first, logic [27:0] past);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_START;
    cfg_data_i <= first;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(REG_START, first);
    cfg_index_i <= REG_END;
    cfg_data_i <= past;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(REG_END, past);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic free_held(int idx);
    held_block_t b;
    b = held_q[idx];
    held_q.delete(idx);
    last_freed = b;
    have_freed = 1;
    send(OP_FREE, b.ord, b.page);
  endtask

  task automatic run_phase(logic [27:0] first, logic [27:0] past, int n, bit do_init);
    int k;
    logic [3:0] ord;
    logic [27:0] page;
    drain();
    set_region(first, past);
    if (do_init) send(OP_INIT, '0, '0);
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 0) quiet = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < 45 || (k < 85 && held_q.size() == 0)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ord = 4'($urandom_range(0, 2));
          6, 7, 8: ord = 4'($urandom_range(0, TOP_ORDER));
          default: ord = 4'($urandom_range(TOP_ORDER + 1, 15));
        endcase
        send(OP_ALLOC, ord, 28'($urandom));
      end else if (k < 85) begin
        free_held($urandom_range(0, held_q.size() - 1));
      end else if (k < 89 && have_freed) begin
        send(OP_FREE, last_freed.ord, last_freed.page);
      end else if (k < 96) begin
        if ($urandom_range(0, 1)) page = 28'(first + $urandom_range(0, 4100));
        else page = 28'($urandom);
        send(OP_FREE, 4'($urandom_range(0, 15)), page);
      end else if (k < 98) begin
        send(OP_UNUSED, 4'($urandom_range(0, 15)), 28'($urandom));
      end else begin
        send(OP_INIT, 4'($urandom_range(0, 15)), 28'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    logic [27:0] s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_INIT;
    block_order_i = '0;
    free_page_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_START;
    cfg_data_i = '0;
    quiet = 0;
    have_freed = 0;
    n_grant = 0;
    n_empty = 0;
    n_reject = 0;
    n_settings = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset region, empty lists, bounds, orders, double free
    send(OP_ALLOC, 4'd0, '0);
    send(OP_FREE, 4'd0, 28'd524287);
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, 4'd0, '0);
    send(OP_ALLOC, 4'd10, '0);
    send(OP_ALLOC, 4'd15, PAGE_MASK);
    send(OP_ALLOC, 4'd5, '0);
    send(OP_FREE, 4'd0, 28'd524287);
    send(OP_FREE, 4'd0, 28'd557056);
    send(OP_FREE, 4'd15, PAGE_MASK);
    send(OP_FREE, 4'd0, '0);
    send(OP_UNUSED, 4'hF, PAGE_MASK);
    free_held(0);
    send(OP_FREE, 4'd15, held_q[0].page);
    held_q.delete(0);
    send(OP_FREE, 4'd5, held_q[0].page);
    send(OP_FREE, 4'd5, held_q[0].page);
    held_q.delete(0);
    send(OP_ALLOC, 4'd5, '0);
    send(OP_ALLOC, 4'd5, '0);
    send(OP_INIT, '0, '0);

    run_phase(28'd0, 28'd1000, 400, 1);
    run_phase(28'hFFFFF00, 28'hFFFFFFF, 250, 1);
    run_phase(28'd100, 28'd50, 60, 1);
    s = 28'($urandom_range(0, 28'h8000000));
    // Lists carried over from the previous setting are read against the new start
    run_phase(s, 28'(s + $urandom_range(1, 3000)), 300, 0);
    run_phase(28'h5555555, 28'h5555555 + 28'd32773, 150, 1);
    run_phase(28'd0, 28'hFFFFFFF, 150, 1);
    run_phase(28'd0, 28'd4096, 450, 1);

    $display("%0d grants, %0d empty-list refusals, %0d rejected frees", n_grant, n_empty,
             n_reject);
    $display("over %0d region settings, %0d cycles", n_settings, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_buddy_page_allocator_core OK");
    end else begin
      $display("tb_buddy_page_allocator_core NOT OK");
    end
    $finish;
  end
endmodule
